@@ sv/sorted_key_level_table_top_macros.svh @@
// Assertion macros for the sorted key level table.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SORTED_KEY_LEVEL_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_LEVEL_TABLE_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define SKLT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define SKLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sklt_pkg.sv @@
// Package for the sorted key level table: widths, codes and cell link types.
// No dependencies.
package sklt_pkg;

    localparam int KEY_W        = 16;
    localparam int LVL_W        = 8;
    localparam int MODE_W       = 2;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OTHER    = 2'd3;

    typedef struct packed {
        logic                    ins_en;
        logic                    upd_en;
        logic signed [KEY_W-1:0] key;
        logic        [LVL_W-1:0] level;
    } t_cell_ctl;

    typedef struct packed {
        logic                    lt;
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic        [LVL_W-1:0] level;
    } t_cell_link;

endpackage

@@ sv/sklt_in_if.sv @@
// Input channel of the sorted key level table: one operation word.
// Depends on sklt_pkg.
interface sklt_in_if
    import sklt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [MODE_W-1:0] mode;
    logic signed [KEY_W-1:0]  key;
    logic        [LVL_W-1:0]  level;

    modport source (output valid, mode, key, level, input ready);
    modport sink   (input valid, mode, key, level, output ready);
endinterface

@@ sv/sklt_out_if.sv @@
// Output channel of the sorted key level table: one result word.
// Depends on sklt_pkg.
interface sklt_out_if
    import sklt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [LVL_W-1:0]    level_out;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    entry_count;

    modport source (output valid, found, position, level_out, status, entry_count,
                    input ready);
    modport sink   (input valid, found, position, level_out, status, entry_count,
                    output ready);
endinterface

@@ sv/sklt_cell.sv @@
// One table cell: holds a key and level, compares against the broadcast key
// and takes its left neighbour's entry when an insert shifts. Uses sklt_pkg.
module sklt_cell
    import sklt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_cell_link i_left,
    input  logic       i_valid,
    output t_cell_link o_link,
    output logic       o_slot,
    output logic       o_hit
);

    logic signed [KEY_W-1:0] r_key;
    logic        [LVL_W-1:0] r_level;
    logic                    lt;

    assign lt     = i_valid && (r_key < i_ctl.key);
    assign o_slot = i_left.lt && !lt;
    assign o_hit  = o_slot && i_valid && (r_key == i_ctl.key);

    assign o_link.lt    = lt;
    assign o_link.valid = i_valid;
    assign o_link.key   = r_key;
    assign o_link.level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (o_slot) begin
                r_key   <= i_ctl.key;
                r_level <= i_ctl.level;
            end else if (!i_left.lt && i_left.valid) begin
                r_key   <= i_left.key;
                r_level <= i_left.level;
            end
        end else if (i_ctl.upd_en && o_hit) begin
            r_level <= i_ctl.level;
        end
    end

endmodule

@@ sv/sorted_key_level_table_top.sv @@
// A result word is registered and appears in the cycle after its operation is accepted.
// Throughput: one operation per cycle while the output is taken; every cell compares and shifts at once.
// The output register is freed as it is taken, so input and output overlap.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending
// result; cell contents are not cleared.
// Depends on sklt_pkg, sklt_in_if, sklt_out_if, sklt_cell and the macro header.
`include "sorted_key_level_table_top_macros.svh"
module sorted_key_level_table_top
    import sklt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic    i_clk,
    input logic    i_rst_n,
    sklt_in_if.sink    i_in,
    sklt_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_valid;
    logic                r_found;
    logic [POS_W-1:0]    r_position;
    logic [LVL_W-1:0]    r_level_out;
    logic [STATUS_W-1:0] r_status;

    t_cell_ctl          ctl;
    t_cell_link         links [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] slot_vec;
    logic [CAPACITY-1:0] hit_vec;

    logic                accept;
    logic                is_ins;
    logic                hit;
    logic                full;
    logic [CNT_W-1:0]    slot;
    logic [LVL_W-1:0]    hit_level;
    logic [CNT_W-1:0]    n_pos;
    logic [STATUS_W-1:0] n_status;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_ins     = (i_in.mode == MODE_INSERT);
    assign full       = (r_count >= CNT_W'(CAPACITY));
    assign hit        = |hit_vec;

    assign ctl.key    = i_in.key;
    assign ctl.level  = i_in.level;
    assign ctl.ins_en = accept && is_ins && !hit && !full;
    assign ctl.upd_en = accept && is_ins && hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_cell_link left;
            assign cell_valid[g] = (CNT_W'(g) < r_count);
            if (g == 0) begin : g_head
                assign left.lt    = 1'b1;
                assign left.valid = 1'b0;
                assign left.key   = '0;
                assign left.level = '0;
            end else begin : g_body
                assign left = links[g-1];
            end
            sklt_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_left  (left),
                .i_valid (cell_valid[g]),
                .o_link  (links[g]),
                .o_slot  (slot_vec[g]),
                .o_hit   (hit_vec[g])
            );
        end
    endgenerate

    always_comb begin
        slot      = (slot_vec == '0) ? CNT_W'(CAPACITY) : '0;
        hit_level = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_vec[i]) begin
                slot = slot | CNT_W'(i);
            end
            if (hit_vec[i]) begin
                hit_level = hit_level | links[i].level;
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_pos    = hit ? slot : r_count;
        n_status = ST_OTHER;
        if (i_in.mode == MODE_CLEAR) begin
            n_count = '0;
            n_pos   = '0;
        end else if (is_ins) begin
            if (hit) begin
                n_status = ST_UPDATED;
            end else if (full) begin
                n_status = ST_DROPPED;
            end else begin
                n_status = ST_INSERTED;
                n_pos    = slot;
                n_count  = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_found     <= hit && (i_in.mode != MODE_CLEAR);
            r_position  <= POS_W'(n_pos);
            r_level_out <= (i_in.mode == MODE_CLEAR) ? '0 : hit_level;
            r_status    <= n_status;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.found       = r_found;
    assign o_out.position    = r_position;
    assign o_out.level_out   = r_level_out;
    assign o_out.status      = r_status;
    assign o_out.entry_count = POS_W'(r_count);

    `SKLT_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count overflow")
    `SKLT_ASSERT_NEXT(a_clear_empties, accept && (i_in.mode == MODE_CLEAR), r_count == '0,
                      "clear left entries")
    `SKLT_ASSERT_IMPL(a_found_status, r_valid && r_found,
                      (r_status == ST_UPDATED) || (r_status == ST_OTHER),
                      "found word with insert or drop status")
    `SKLT_ASSERT_IMPL(a_one_slot, 1'b1, $onehot0(slot_vec) && $onehot0(hit_vec),
                      "more than one slot cell")

endmodule

@@ verif/sorted_key_level_table_top_tb.sv @@
// Self-checking testbench for sorted_key_level_table_top: drives operation words,
// predicts every result word with its own sorted table and compares them.
// Depends on sklt_pkg, sklt_in_if, sklt_out_if and the block itself.
module sorted_key_level_table_top_tb;
    import sklt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_OPS = 1000;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD = 80;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [LVL_W-1:0]    level_out;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    entry_count;
    } t_table_result;

    class sorted_table_scoreboard;
        logic signed [KEY_W-1:0] keys [DEF_CAPACITY];
        logic [LVL_W-1:0]        levels [DEF_CAPACITY];
        int unsigned             used;
        t_table_result           pending_results[$];
        int unsigned             mismatches;

        function void note_op(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                              logic [LVL_W-1:0] lvl);
            t_table_result r;
            int unsigned   slot;
            bit            hit;
            r = '0;
            r.status = ST_OTHER;
            if (mode == MODE_CLEAR) begin
                used = 0;
            end else begin
                slot = 0;
                while (slot < used && keys[slot] < key) slot++;
                hit = slot < used && keys[slot] == key;
                if (hit) begin
                    r.found = 1'b1;
                    r.position = POS_W'(slot);
                    r.level_out = levels[slot];
                end else begin
                    r.position = POS_W'(used);
                end
                if (mode == MODE_INSERT) begin
                    if (hit) begin
                        levels[slot] = lvl;
                        r.status = ST_UPDATED;
                    end else if (used >= DEF_CAPACITY) begin
                        r.status = ST_DROPPED;
                    end else begin
                        for (int i = used; i > slot; i--) begin
                            keys[i] = keys[i-1];
                            levels[i] = levels[i-1];
                        end
                        keys[slot] = key;
                        levels[slot] = lvl;
                        used++;
                        r.position = POS_W'(slot);
                        r.status = ST_INSERTED;
                    end
                end
            end
            r.entry_count = POS_W'(used);
            pending_results.push_back(r);
        endfunction

        function void check_result(t_table_result got);
            t_table_result exp;
            if (pending_results.size() == 0) begin
                $error("Result word arrived with no operation outstanding.");
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.found !== exp.found) begin
                $error("found: expected %0d, got %0d", exp.found, got.found);
                mismatches++;
            end
            if (got.position !== exp.position) begin
                $error("position: expected %0d, got %0d", exp.position, got.position);
                mismatches++;
            end
            if (got.level_out !== exp.level_out) begin
                $error("level_out: expected %0d, got %0d", exp.level_out, got.level_out);
                mismatches++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count,
                       got.entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    bit   hold_req;
    int   idle_cycles;
    logic signed [KEY_W-1:0] recent_keys[$];
    sorted_table_scoreboard sb = new();

    sklt_in_if  op_if();
    sklt_out_if res_if();

    sorted_key_level_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_table_result got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.found = res_if.found;
                got.position = res_if.position;
                got.level_out = res_if.level_out;
                got.status = res_if.status;
                got.entry_count = res_if.entry_count;
                sb.check_result(got);
            end
            if (op_if.valid && op_if.ready) begin
                sb.note_op(op_if.mode, op_if.key, op_if.level);
            end
            if ((res_if.valid && res_if.ready) || (op_if.valid && op_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic signed [KEY_W-1:0] key,
                           input logic [LVL_W-1:0] lvl);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            op_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        op_if.valid <= 1'b1;
        op_if.mode <= mode;
        op_if.key <= key;
        op_if.level <= lvl;
        do @(posedge i_clk); while (!(op_if.valid && op_if.ready));
        @(negedge i_clk);
        if (mode == MODE_INSERT) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 24) void'(recent_keys.pop_front());
        end
    endtask

    task automatic wait_drained();
        op_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (r < 7)
            return KEY_W'($urandom_range(0, 16) - 8);
        return KEY_W'($urandom);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return MODE_CLEAR;
        if (r < 6) return MODE_SPARE;
        if (r < 33) return MODE_LOOKUP;
        return MODE_INSERT;
    endfunction

    initial begin : stimulus
        op_if.valid <= 1'b0;
        op_if.mode <= MODE_LOOKUP;
        op_if.key <= '0;
        op_if.level <= '0;
        i_rst_n <= 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_op(MODE_LOOKUP, 16'sd0, 8'h00);
        send_op(MODE_INSERT, 16'sd0, 8'h55);
        send_op(MODE_INSERT, -16'sd32768, 8'h00);
        send_op(MODE_INSERT, 16'sd32767, 8'hFF);
        send_op(MODE_INSERT, -16'sd1, 8'hAA);
        send_op(MODE_INSERT, 16'sd0, 8'h12);
        send_op(MODE_LOOKUP, 16'sd32767, 8'h00);
        send_op(MODE_LOOKUP, 16'sd5, 8'hFF);
        send_op(MODE_SPARE, 16'sd0, 8'hFF);
        send_op(MODE_CLEAR, 16'sd32767, 8'hFF);
        send_op(MODE_LOOKUP, 16'sd0, 8'h00);
        for (int i = 0; i < DEF_CAPACITY; i++)
            send_op(MODE_INSERT, KEY_W'(3000 - 400 * i), LVL_W'($urandom));
        send_op(MODE_INSERT, 16'sd1, 8'h33);
        send_op(MODE_INSERT, 16'sd3000, 8'h44);
        send_op(MODE_LOOKUP, -16'sd3000, 8'h00);
        send_op(MODE_CLEAR, 16'sd0, 8'h00);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS * 3 / 10) hold_req = 1'b1;
            if (n == RANDOM_OPS * 6 / 10) wait_drained();
            if (n == RANDOM_OPS * 9 / 10) quiet = 1'b1;
            send_op(pick_mode(), pick_key(), LVL_W'($urandom));
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
